### hw/rtl/mab_pkg.sv
`default_nettype none

package mab_pkg;

	localparam int BlkW = 16;
	localparam int NibW = 4;
	localparam logic [NibW-1:0] Rcon1 = 4'b0001;
	localparam logic [NibW-1:0] Rcon2 = 4'b0010;
	localparam logic [NibW-1:0] GfRed = 4'b0011;

	typedef logic [BlkW-1:0] blk_t;
	typedef logic [NibW-1:0] nib_t;

	typedef enum logic {
		MODE_ENC = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	typedef struct packed {
		blk_t k0;
		blk_t k1;
		blk_t k2;
	} rkeys_t;

	function automatic nib_t sbox_fwd(input nib_t x);
		nib_t y;
		case (x)
			4'h0: y = 4'hE;
			4'h1: y = 4'h4;
			4'h2: y = 4'hD;
			4'h3: y = 4'h1;
			4'h4: y = 4'h2;
			4'h5: y = 4'hF;
			4'h6: y = 4'hB;
			4'h7: y = 4'h8;
			4'h8: y = 4'h3;
			4'h9: y = 4'hA;
			4'hA: y = 4'h6;
			4'hB: y = 4'hC;
			4'hC: y = 4'h5;
			4'hD: y = 4'h9;
			4'hE: y = 4'h0;
			default: y = 4'h7;
		endcase
		return y;
	endfunction

	function automatic nib_t sbox_inv(input nib_t x);
		nib_t y;
		case (x)
			4'h0: y = 4'hE;
			4'h1: y = 4'h3;
			4'h2: y = 4'h4;
			4'h3: y = 4'h8;
			4'h4: y = 4'h1;
			4'h5: y = 4'hC;
			4'h6: y = 4'hA;
			4'h7: y = 4'hF;
			4'h8: y = 4'h7;
			4'h9: y = 4'hD;
			4'hA: y = 4'h9;
			4'hB: y = 4'h6;
			4'hC: y = 4'hB;
			4'hD: y = 4'h2;
			4'hE: y = 4'h0;
			default: y = 4'h5;
		endcase
		return y;
	endfunction

	function automatic nib_t gf_mul2(input nib_t x);
		return {x[2:0], 1'b0} ^ (x[3] ? GfRed : 4'h0);
	endfunction

	function automatic nib_t gf_mul3(input nib_t x);
		return gf_mul2(x) ^ x;
	endfunction

	function automatic blk_t sub_fwd(input blk_t b);
		return {sbox_fwd(b[15:12]), sbox_fwd(b[11:8]), sbox_fwd(b[7:4]), sbox_fwd(b[3:0])};
	endfunction

	function automatic blk_t sub_inv(input blk_t b);
		return {sbox_inv(b[15:12]), sbox_inv(b[11:8]), sbox_inv(b[7:4]), sbox_inv(b[3:0])};
	endfunction

	// swap nibbles 1 and 3
	function automatic blk_t shift_row(input blk_t b);
		return {b[15:12], b[3:0], b[7:4], b[11:8]};
	endfunction

	function automatic blk_t mix_column(input blk_t b);
		nib_t a0;
		nib_t a1;
		nib_t a2;
		nib_t a3;
		a0 = b[15:12];
		a1 = b[11:8];
		a2 = b[7:4];
		a3 = b[3:0];
		return {gf_mul3(a0) ^ gf_mul2(a1), gf_mul2(a0) ^ gf_mul3(a1),
			gf_mul3(a2) ^ gf_mul2(a3), gf_mul2(a2) ^ gf_mul3(a3)};
	endfunction

	function automatic blk_t next_rkey(input blk_t k, input nib_t rc);
		nib_t w0;
		nib_t w1;
		nib_t w2;
		nib_t w3;
		w0 = k[15:12] ^ sbox_fwd(k[3:0]) ^ rc;
		w1 = k[11:8] ^ w0;
		w2 = k[7:4] ^ w1;
		w3 = k[3:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	function automatic rkeys_t derive_keys(input blk_t key);
		rkeys_t rk;
		rk.k0 = key;
		rk.k1 = next_rkey(rk.k0, Rcon1);
		rk.k2 = next_rkey(rk.k1, Rcon2);
		return rk;
	endfunction

	function automatic blk_t encrypt(input blk_t b, input rkeys_t rk);
		blk_t n;
		n = sub_fwd(b ^ rk.k0);
		n = mix_column(shift_row(n)) ^ rk.k1;
		n = shift_row(sub_fwd(n)) ^ rk.k2;
		return n;
	endfunction

	function automatic blk_t decrypt(input blk_t b, input rkeys_t rk);
		blk_t n;
		n = sub_inv(shift_row(b ^ rk.k2)) ^ rk.k1;
		n = sub_inv(shift_row(mix_column(n))) ^ rk.k0;
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mini_aes_block_cipher.sv
// an accepted input block is held in the input register, then its result in the result register on the master side
// throughput: one block per cycle while the master side accepts; input register, one cipher pass, result register
// round keys are held in registers, recomputed on each key write
// reset: asynchronous, active low; both stages empty, key and round keys of key zero
`default_nettype none

module mini_aes_block_cipher (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [15:0]          cfg_wr_data,   // cipher_key
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	input  wire mab_pkg::blk_t        s_axis_tdata,  // [15:0] data_block
	input  wire logic                 s_axis_tuser,  // [0] mode
	input  wire logic                 s_axis_tlast,  // last_in
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output      mab_pkg::blk_t        m_axis_tdata,  // [15:0] result_block
	output      logic                 m_axis_tlast   // last_out
);
	import mab_pkg::*;

	rkeys_t rkeys_q;

	logic  valid_s1;
	blk_t  blk_s1;
	mode_t mode_s1;
	logic  last_s1;

	logic  valid_s2;
	blk_t  result_s2;
	logic  last_s2;

	logic  s_fire;
	logic  adv_s1;
	blk_t  result_d;

	assign adv_s1        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		if (mode_s1 == MODE_DEC) begin
			result_d = decrypt(blk_s1, rkeys_q);
		end else begin
			result_d = encrypt(blk_s1, rkeys_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rkeys_q <= derive_keys(16'h0000);
		end else if (cfg_wr_en) begin
			rkeys_q <= derive_keys(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			blk_s1  <= s_axis_tdata;
			mode_s1 <= mode_t'(s_axis_tuser);
			last_s1 <= s_axis_tlast;
		end
		if (adv_s1 && valid_s1) begin
			result_s2 <= result_d;
			last_s2   <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;
	assign m_axis_tlast  = last_s2;

	// input side stalls only when both stages hold blocks and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled with a free stage");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> valid_s1)
		else $error("accepted block lost in stage 1");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> (valid_s1 && $stable(blk_s1) && $stable(last_s1)))
		else $error("stage 1 changed while blocked");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s1) |=> valid_s2)
		else $error("block dropped between stages");

endmodule

`default_nettype wire
